@@ hw/rtl/itoa_pkg.sv @@
// Shared types, constants and helpers for the integer to ASCII formatter.
`default_nettype none

package itoa_pkg;

    // Stream field widths
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 7;
    localparam int DIGIT_W = 4;

    // Largest digit count of a 32-bit magnitude in base ten
    localparam int NUM_DIGITS = 10;
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    // Reciprocal of ten: floor(x * RECIP10 / 2^35) == x / 10 for any 32-bit x
    localparam int                 PROD_W      = 2 * VALUE_W;
    localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam int                 HEX_SHIFT   = 4;

    // Mode codes carried in the input side band
    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_HEX = 1'b1;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

    // Control from the sequencer to the divide unit
    typedef struct packed {
        logic load;
        logic hex;
    } t_step_ctl;

    // Quotient and remainder of one digit step
    typedef struct packed {
        logic [VALUE_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } t_step_res;

    // Digit value to lowercase ASCII
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DEC_BASE) begin
            return CH_ZERO + d_ext;
        end
        return CH_A + d_ext - CHAR_W'(DEC_BASE);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itoa_div_unit.sv @@
// Shared digit step: divides by ten (reciprocal multiply) or sixteen (shift).
`default_nettype none

module itoa_div_unit (
    input  wire logic                    i_clk,
    input  wire itoa_pkg::t_step_ctl     i_ctl,
    input  wire logic [itoa_pkg::VALUE_W-1:0] i_x,
    output itoa_pkg::t_step_res          o_res
);
    import itoa_pkg::*;

    logic [VALUE_W-1:0] r_x;
    logic               r_hex;
    logic [PROD_W-1:0]  r_prod;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] rem_full;

    // Operand and product capture; the product of the multiply is registered here
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x    <= i_x;
            r_hex  <= i_ctl.hex;
            r_prod <= PROD_W'(i_x) * PROD_W'(RECIP10);
        end
    end

    // Quotient from product or shift; remainder by shift-and-subtract
    always_comb begin
        if (r_hex) begin
            quot = r_x >> HEX_SHIFT;
        end else begin
            quot = VALUE_W'(r_prod[PROD_W-1:RECIP_SHIFT]);
        end
        rem_full = r_hex ? (r_x - (quot << HEX_SHIFT))
                         : (r_x - (quot << 3) - (quot << 1));
        o_res.quot = quot;
        o_res.rem  = rem_full[DIGIT_W-1:0];
    end

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_ascii_formatter_core.sv @@
// Top level: formats a 32-bit word as signed decimal or lowercase hex ASCII text.
//
// Input stream s_*: tdata carries the 32-bit value, tuser the mode
// (0 signed decimal, 1 unsigned lowercase hex). Output stream m_*: one request
// per character, most significant first, tdata[6:0] the ASCII code, tlast on
// the final character. No leading zeros, no prefix; zero prints as '0', a
// negative decimal value gets a leading '-'.
// Digits are produced least significant first by one shared divide unit,
// each through a registered reciprocal multiply (decimal) or shift (hex), then a
// remainder step, into a ten-entry digit buffer, then sent out in reverse order.
// After the last digit step the characters leave one per cycle while
// m_tready is high. The block takes no new input meanwhile: s_tready rises
// again once the last character has been loaded into the output register.
// A stalled receiver holds the output register and pauses the character
// sequencer; the block does not lose or repeat characters.
// Reset (synchronous, active low) returns to idle with no output pending.
`default_nettype none

module integer_to_ascii_formatter_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [itoa_pkg::VALUE_W-1:0]   s_tdata,  // [31:0] value
    input  wire logic                           s_tuser,  // [0] mode
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [7:0]                     m_tdata,  // [6:0] out_char, [7] zero
    output      logic                           m_tlast   // last
);
    import itoa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          r_state;
    logic [VALUE_W-1:0]  r_x;
    logic                r_hex;
    logic                r_neg;
    logic [IDX_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_idx;
    logic [DIGIT_W-1:0]  r_dig [NUM_DIGITS];
    logic                r_mvalid;
    logic [CHAR_W-1:0]   r_mchar;
    logic                r_mlast;

    t_step_ctl           step_ctl;
    t_step_res           step_res;
    logic                in_take;
    logic                out_free;
    logic                in_neg;

    assign s_tready = (r_state == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !r_mvalid || m_tready;
    assign in_neg   = (s_tuser == MODE_DEC) && s_tdata[VALUE_W-1];

    assign step_ctl.load = (r_state == ST_MUL);
    assign step_ctl.hex  = r_hex;

    itoa_div_unit u_div (
        .i_clk (i_clk),
        .i_ctl (step_ctl),
        .i_x   (r_x),
        .o_res (step_res)
    );

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mvalid <= 1'b0;
        end else begin
            // Output valid: set on a new character, held while stalled
            r_mvalid <= ((r_state == ST_EMIT) && out_free) || (r_mvalid && !m_tready);
            unique case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_REM;
                end
                ST_REM: begin
                    r_state <= (step_res.quot == '0) ? ST_EMIT : ST_MUL;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (!r_neg && r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath: operand, digit buffer and output register
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    r_x   <= in_neg ? (VALUE_W'(0) - s_tdata) : s_tdata;
                    r_hex <= s_tuser;
                    r_neg <= in_neg;
                    r_cnt <= '0;
                end
            end
            ST_REM: begin
                r_dig[r_cnt] <= step_res.rem;
                if (step_res.quot == '0) begin
                    r_idx <= r_cnt;
                end else begin
                    r_x   <= step_res.quot;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (r_neg) begin
                        r_mchar <= CH_MINUS;
                        r_mlast <= 1'b0;
                        r_neg   <= 1'b0;
                    end else begin
                        r_mchar <= digit_to_ascii(r_dig[r_idx]);
                        r_mlast <= (r_idx == '0);
                        if (r_idx != '0) begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = {1'b0, r_mchar};
    assign m_tlast  = r_mlast;

endmodule

`default_nettype wire

@@ hw/rtl/itoa_checker.sv @@
// Port-level checks for the formatter core, bound to the top level.
`default_nettype none

module itoa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // Stalled output request holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // Only sign, decimal digits or lowercase hex digits appear
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata == 8'h2D)
                  || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
                  || (m_tdata >= 8'h61 && m_tdata <= 8'h66))
        else $error("character outside the output set");

    // A sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tdata != 8'h2D)
        else $error("sign marked as last character");

    // The block is busy right after taking an input request
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again without conversion");

endmodule

bind integer_to_ascii_formatter_core itoa_checker u_itoa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
